/* rtl/etf_pkg.sv */
// shared constants, types and helpers of the escape time fractal pixel engine
// no dependencies
`timescale 1ns / 1ps

package etf_pkg;

  localparam int IMAGE_WIDTH   = 1024;
  localparam int IMAGE_HEIGHT  = 1024;
  localparam int FRACTION_BITS = 28;

  localparam int COORD_W   = 10;
  localparam int ITER_W    = 12;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZOOM       = 4'd0,
    REG_SHIFT_RE   = 4'd1,
    REG_SHIFT_IM   = 4'd2,
    REG_MAX_ITER   = 4'd3,
    REG_THRESHOLD  = 4'd4,
    REG_JULIA_MODE = 4'd5,
    REG_JULIA_RE   = 4'd6,
    REG_JULIA_IM   = 4'd7
  } etf_reg_e;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_MUL,
    CORE_STEP,
    CORE_DONE
  } etf_core_e;

  typedef struct packed {
    logic [30:0]        zoom;
    logic signed [31:0] shift_re;
    logic signed [31:0] shift_im;
    logic [ITER_W-1:0]  max_iter;
    logic [30:0]        threshold;
    logic               julia_mode;
    logic signed [31:0] julia_re;
    logic signed [31:0] julia_im;
  } etf_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic signed [31:0] pr;
    logic signed [31:0] pi;
  } etf_pt_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic fits32(input logic signed [63:0] v);
    return (v[63:31] == '0) || (v[63:31] == '1);
  endfunction

endpackage

/* rtl/etf_front.sv */
// front end: accepts pixel beats, maps them onto the complex plane, applies zoom and shift
// depends on etf_pkg
`timescale 1ns / 1ps

module etf_front import etf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [COORD_W-1:0] pixel_x_i,
  input  logic [COORD_W-1:0] pixel_y_i,
  input  etf_cfg_t           cfg_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output etf_pt_t            q_data_o
);

  localparam logic signed [63:0] Span = 64'sd4 <<< FRACTION_BITS;
  localparam logic signed [63:0] Half = 64'sd2 <<< FRACTION_BITS;

  logic               s1_v_q, s2_v_q;
  logic [COORD_W-1:0] s1_x_q, s1_y_q, s2_x_q, s2_y_q;
  logic signed [63:0] prod_r_q, prod_i_q;
  logic signed [63:0] prod_r_d, prod_i_d;
  logic signed [31:0] map_r, map_i;
  logic               s2_move, s1_move;

  assign s2_move = s2_v_q && !q_full_i;
  assign s1_move = s1_v_q && (!s2_v_q || s2_move);
  assign full    = s1_v_q && !s1_move;

  always_comb begin
    map_r = sat32((signed'(64'(s1_x_q)) * Span) / IMAGE_WIDTH - Half);
    map_i = sat32((signed'(64'(s1_y_q)) * Span) / IMAGE_HEIGHT - Half);
    prod_r_d = map_r * signed'({1'b0, cfg_i.zoom});
    prod_i_d = map_i * signed'({1'b0, cfg_i.zoom});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (push && !full) s1_v_q <= 1'b1;
      else if (s1_move) s1_v_q <= 1'b0;
      if (s1_move) s2_v_q <= 1'b1;
      else if (s2_move) s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !full) begin
      s1_x_q <= pixel_x_i;
      s1_y_q <= pixel_y_i;
    end
    if (s1_move) begin
      s2_x_q   <= s1_x_q;
      s2_y_q   <= s1_y_q;
      prod_r_q <= prod_r_d;
      prod_i_q <= prod_i_d;
    end
  end

  assign q_push_o    = s2_move;
  assign q_data_o.px = s2_x_q;
  assign q_data_o.py = s2_y_q;
  assign q_data_o.pr = sat32((prod_r_q >>> FRACTION_BITS) + 64'(cfg_i.shift_re));
  assign q_data_o.pi = sat32((prod_i_q >>> FRACTION_BITS) + 64'(cfg_i.shift_im));

endmodule

/* rtl/etf_queue.sv */
// short queue of mapped points between front end and iteration core
// depends on etf_pkg
`timescale 1ns / 1ps

module etf_queue import etf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  etf_pt_t wr_data_i,
  output logic    full_o,
  input  logic    rd_i,
  output logic    valid_o,
  output etf_pt_t rd_data_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  etf_pt_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = cnt_q == (PtrW+1)'(QUEUE_DEPTH);
  assign valid_o   = cnt_q != '0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

/* rtl/etf_core.sv */
// iteration core: runs z = z^2 + c, a multiply state and an update state per step, and holds the result beat
// depends on etf_pkg
`timescale 1ns / 1ps

module etf_core import etf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  etf_cfg_t           cfg_i,
  input  logic               q_valid_i,
  input  etf_pt_t            q_data_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [COORD_W-1:0] out_x_o,
  output logic [COORD_W-1:0] out_y_o,
  output logic               escaped_o,
  output logic [ITER_W-1:0]  escape_iteration_o
);

  etf_core_e state_q, state_d;

  logic signed [31:0] zr_q, zi_q, cr_q, ci_q;
  logic signed [63:0] sq_r_q, sq_i_q, xp_q;
  logic [ITER_W-1:0]  iter_q, res_it_q;
  logic               pend_q, res_esc_q;
  logic [COORD_W-1:0] px_q, py_q;
  logic               out_v_q;

  logic signed [63:0] nr, ni;
  logic [63:0]        mag, limit;
  logic               mag_esc, at_limit, ovf, out_free;

  always_comb begin
    mag      = 64'(sq_r_q) + 64'(sq_i_q);
    limit    = 64'(cfg_i.threshold) << FRACTION_BITS;
    mag_esc  = pend_q && (mag > limit);
    at_limit = iter_q == cfg_i.max_iter;
    nr       = ((sq_r_q - sq_i_q) >>> FRACTION_BITS) + 64'(cr_q);
    ni       = (xp_q >>> (FRACTION_BITS-1)) + 64'(ci_q);
    ovf      = !fits32(nr) || !fits32(ni);
    out_free = !out_v_q || pop;
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      CORE_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = CORE_MUL;
        end
      end
      CORE_MUL: state_d = CORE_STEP;
      CORE_STEP: begin
        if (mag_esc || at_limit || ovf) state_d = CORE_DONE;
        else state_d = CORE_MUL;
      end
      CORE_DONE: begin
        if (out_free) state_d = CORE_IDLE;
      end
      default: state_d = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == CORE_DONE && out_free) out_v_q <= 1'b1;
      else if (pop) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      CORE_IDLE: begin
        px_q   <= q_data_i.px;
        py_q   <= q_data_i.py;
        iter_q <= '0;
        pend_q <= 1'b0;
        if (cfg_i.julia_mode) begin
          zr_q <= q_data_i.pr;
          zi_q <= q_data_i.pi;
          cr_q <= cfg_i.julia_re;
          ci_q <= cfg_i.julia_im;
        end else begin
          zr_q <= '0;
          zi_q <= '0;
          cr_q <= q_data_i.pr;
          ci_q <= q_data_i.pi;
        end
      end
      CORE_MUL: begin
        sq_r_q <= zr_q * zr_q;
        sq_i_q <= zi_q * zi_q;
        xp_q   <= zr_q * zi_q;
      end
      CORE_STEP: begin
        priority if (mag_esc) begin
          res_esc_q <= 1'b1;
          res_it_q  <= iter_q - 1'b1;
        end else if (at_limit) begin
          res_esc_q <= 1'b0;
          res_it_q  <= '0;
        end else if (ovf) begin
          res_esc_q <= 1'b1;
          res_it_q  <= iter_q;
        end else begin
          zr_q   <= nr[31:0];
          zi_q   <= ni[31:0];
          iter_q <= iter_q + 1'b1;
          pend_q <= 1'b1;
        end
      end
      CORE_DONE: begin
        if (out_free) begin
          out_x_o            <= px_q;
          out_y_o            <= py_q;
          escaped_o          <= res_esc_q;
          escape_iteration_o <= res_it_q;
        end
      end
      default: ;
    endcase
  end

  assign empty = !out_v_q;

endmodule

/* rtl/escape_time_fractal_pixel.sv */
// top level of the escape time fractal pixel engine: registers, front end, queue, core
// depends on etf_pkg, etf_front, etf_queue, etf_core
// the core takes one pixel at a time and steps it through alternating multiply and update
//   states until it is done; the front end maps the next pixels meanwhile
// reset: registers take their defaults (zoom 1.0, limit 100, threshold 4.0), queue empty
`timescale 1ns / 1ps

module escape_time_fractal_pixel import etf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [COORD_W-1:0]   pixel_x_i,
  input  logic [COORD_W-1:0]   pixel_y_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [COORD_W-1:0]   out_x_o,
  output logic [COORD_W-1:0]   out_y_o,
  output logic                 escaped_o,
  output logic [ITER_W-1:0]    escape_iteration_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  etf_cfg_t cfg_q;
  etf_pt_t  wr_pt, rd_pt;
  logic     q_push, q_full, q_pop, q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom       <= 31'(1 << FRACTION_BITS);
      cfg_q.shift_re   <= '0;
      cfg_q.shift_im   <= '0;
      cfg_q.max_iter   <= ITER_W'(100);
      cfg_q.threshold  <= 31'(4 << FRACTION_BITS);
      cfg_q.julia_mode <= 1'b0;
      cfg_q.julia_re   <= '0;
      cfg_q.julia_im   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ZOOM:       cfg_q.zoom       <= cfg_data_i[30:0];
        REG_SHIFT_RE:   cfg_q.shift_re   <= cfg_data_i;
        REG_SHIFT_IM:   cfg_q.shift_im   <= cfg_data_i;
        REG_MAX_ITER:   cfg_q.max_iter   <= cfg_data_i[ITER_W-1:0];
        REG_THRESHOLD:  cfg_q.threshold  <= cfg_data_i[30:0];
        REG_JULIA_MODE: cfg_q.julia_mode <= cfg_data_i[0];
        REG_JULIA_RE:   cfg_q.julia_re   <= cfg_data_i;
        REG_JULIA_IM:   cfg_q.julia_im   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  etf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (wr_pt)
  );

  etf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_push),
    .wr_data_i (wr_pt),
    .full_o    (q_full),
    .rd_i      (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (rd_pt)
  );

  etf_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_valid_i          (q_valid),
    .q_data_i           (rd_pt),
    .q_pop_o            (q_pop),
    .empty              (empty),
    .pop                (pop),
    .out_x_o            (out_x_o),
    .out_y_o            (out_y_o),
    .escaped_o          (escaped_o),
    .escape_iteration_o (escape_iteration_o)
  );

endmodule

/* rtl/etf_checker.sv */
// port level checks of the escape time fractal pixel engine, bound to the top level
// depends on etf_pkg and escape_time_fractal_pixel
`timescale 1ns / 1ps

module etf_checker import etf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [COORD_W-1:0] out_x_o,
  input logic [COORD_W-1:0] out_y_o,
  input logic               escaped_o,
  input logic [ITER_W-1:0]  escape_iteration_o
);

  // a waiting result beat holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_x_o) && $stable(out_y_o)
      && $stable(escaped_o))
    else $error("result beat changed while waiting");

  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !escaped_o |-> escape_iteration_o == '0)
    else $error("inside pixel with nonzero iteration");

  // escape index is below the limit, and the limit is at most all ones
  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && escaped_o |-> escape_iteration_o != '1)
    else $error("escape iteration out of range");

endmodule

bind escape_time_fractal_pixel etf_checker u_etf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .empty              (empty),
  .pop                (pop),
  .out_x_o            (out_x_o),
  .out_y_o            (out_y_o),
  .escaped_o          (escaped_o),
  .escape_iteration_o (escape_iteration_o)
);
